// File: design/id_range_list_parser_top_macros.svh
// assertion macros for the id range list parser
// used by id_range_list_parser_top; expects clk and rst_n in scope
`ifndef ID_RANGE_LIST_PARSER_TOP_MACROS_SVH
`define ID_RANGE_LIST_PARSER_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define IRLP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define IRLP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/irlp_pkg.sv
// shared types and constants of the id range list parser
// no dependencies; imported by id_range_list_parser_top
package irlp_pkg;

  // field scan phase of the current subfield
  typedef enum logic [1:0] {
    PH_BLANK  = 2'd0,
    PH_DIGITS = 2'd1,
    PH_TRAIL  = 2'd2,
    PH_BAD    = 2'd3
  } phase_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_RANGE    = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_NO_RANGE = 2'd2
  } status_t;

  localparam int unsigned CharW = 8;
  localparam int unsigned IdW   = 16;
  localparam int unsigned ValW  = 32;
  localparam int unsigned DigW  = 35;

  localparam logic [CharW-1:0] ChComma = 8'h2C;
  localparam logic [CharW-1:0] ChDash  = 8'h2D;
  localparam logic [CharW-1:0] ChSpace = 8'h20;
  localparam logic [CharW-1:0] ChTab   = 8'h09;
  localparam logic [CharW-1:0] ChLf    = 8'h0A;
  localparam logic [CharW-1:0] ChCr    = 8'h0D;
  localparam logic [CharW-1:0] ChZero  = 8'h30;
  localparam logic [CharW-1:0] ChNine  = 8'h39;

  // saturation point of a parsed number, 2^31
  localparam logic [ValW-1:0] NumLimit = 32'h8000_0000;
  localparam logic [1:0]      DashMax  = 2'd3;

  function automatic logic is_blank(input logic [CharW-1:0] c);
    return (c == ChSpace) || (c == ChTab) || (c == ChLf) || (c == ChCr);
  endfunction

endpackage

// File: design/id_range_list_parser_top.sv
// id range list parser: one text byte per transaction in, id ranges and status out
// depends on irlp_pkg and id_range_list_parser_top_macros.svh
// Throughput: one byte per cycle while the result register is empty or out_tready
// is high; input register, then one parse step into the result register, with the
// digit update a shift-add of the running value.
// Reset: rst_n synchronous active low; clears the parse state and all valid flags.
// After a byte marked tlast the parse state returns to its reset value.
`include "id_range_list_parser_top_macros.svh"

module id_range_list_parser_top
  import irlp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  input  logic        in_tlast,   // end_of_text
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [15:0] first_id, [31:16] last_id
  output logic [1:0]  out_tuser,  // [1:0] status
  output logic        out_tlast   // final_res
);

  // input register
  logic             s1_valid_r;
  logic [CharW-1:0] s1_char_r;
  logic             s1_eot_r;

  // parse state
  logic [1:0]      dash_cnt_r, dash_cnt_nxt;
  phase_t          phase_r, phase_nxt;
  logic            first_ok_r, first_ok_nxt;
  logic            second_ok_r, second_ok_nxt;
  logic [IdW-1:0]  first_val_r, first_val_nxt;
  logic            first_ovf_r, first_ovf_nxt;
  logic [IdW-1:0]  second_val_r, second_val_nxt;
  logic            second_ovf_r, second_ovf_nxt;
  logic [ValW-1:0] cur_val_r, cur_val_nxt;
  logic            aborted_r, aborted_nxt;

  // result register
  logic            out_valid_r, out_valid_nxt;
  logic [IdW-1:0]  res_first_r, res_last_r;
  status_t         res_status_r;
  logic            res_final_r;

  logic            advance, proc_fire;
  logic            res_load;
  logic [IdW-1:0]  ld_first, ld_last;
  status_t         ld_status;

  // byte classes
  logic            is_comma, is_dash, is_digit, is_space;
  // state after taking the byte, before any close
  logic [1:0]      u_dash;
  phase_t          u_phase;
  logic            u_fok, u_sok, u_fovf, u_sovf;
  logic [IdW-1:0]  u_fval, u_sval;
  logic [ValW-1:0] u_cur;
  logic [DigW-1:0] dig_sum;
  logic            take_ok;
  // close evaluation
  logic            do_close, have, cur_ok, cur_blank;
  logic [IdW-1:0]  lo_val, hi_val;
  logic            lo_ovf, hi_ovf;
  logic            kind_ovf, kind_range;

  // handshake control
  assign advance   = !out_valid_r || out_tready;
  assign proc_fire = s1_valid_r && advance;
  assign in_tready = !s1_valid_r || advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_char_r <= in_tdata[CharW-1:0];
      s1_eot_r  <= in_tlast;
    end
  end

  // byte classification
  assign is_comma = (s1_char_r == ChComma);
  assign is_dash  = (s1_char_r == ChDash);
  assign is_space = is_blank(s1_char_r);
  assign is_digit = (s1_char_r >= ChZero) && (s1_char_r <= ChNine);

  // running value times ten plus digit
  assign dig_sum = ({3'b000, cur_val_r} << 3) + ({3'b000, cur_val_r} << 1)
                 + DigW'(s1_char_r - ChZero);
  assign take_ok = (phase_r == PH_DIGITS) || (phase_r == PH_TRAIL);

  // take the byte into the part
  always_comb begin
    u_dash  = dash_cnt_r;
    u_phase = phase_r;
    u_fok   = first_ok_r;
    u_sok   = second_ok_r;
    u_fval  = first_val_r;
    u_fovf  = first_ovf_r;
    u_sval  = second_val_r;
    u_sovf  = second_ovf_r;
    u_cur   = cur_val_r;
    if (is_dash) begin
      if (dash_cnt_r == 2'd0) begin
        u_fok  = take_ok;
        u_fval = cur_val_r[IdW-1:0];
        u_fovf = cur_val_r[ValW-1];
      end else if (dash_cnt_r == 2'd1) begin
        u_sok  = take_ok;
        u_sval = cur_val_r[IdW-1:0];
        u_sovf = cur_val_r[ValW-1];
      end
      if (dash_cnt_r != DashMax) begin
        u_dash = dash_cnt_r + 2'd1;
      end
      u_phase = PH_BLANK;
      u_cur   = '0;
    end else if (!is_comma) begin
      if (is_space) begin
        if (phase_r == PH_DIGITS) begin
          u_phase = PH_TRAIL;
        end
      end else if (is_digit) begin
        if ((phase_r == PH_BLANK) || (phase_r == PH_DIGITS)) begin
          u_phase = PH_DIGITS;
          if (!cur_val_r[ValW-1]) begin
            u_cur = (dig_sum >= DigW'(NumLimit)) ? NumLimit : dig_sum[ValW-1:0];
          end
        end else begin
          u_phase = PH_BAD;
        end
      end else begin
        u_phase = PH_BAD;
      end
    end
  end

  // close the part on comma or end of text
  assign do_close  = is_comma || s1_eot_r;
  assign cur_ok    = (u_phase == PH_DIGITS) || (u_phase == PH_TRAIL);
  assign cur_blank = (u_phase == PH_BLANK);

  always_comb begin
    have   = 1'b0;
    lo_val = u_cur[IdW-1:0];
    hi_val = u_cur[IdW-1:0];
    lo_ovf = u_cur[ValW-1];
    hi_ovf = u_cur[ValW-1];
    case (u_dash)
      2'd0: begin
        have = cur_ok;
      end
      2'd1: begin
        have   = u_fok && cur_ok;
        lo_val = u_fval;
        lo_ovf = u_fovf;
      end
      2'd2: begin
        have   = cur_blank && u_fok && u_sok;
        lo_val = u_fval;
        lo_ovf = u_fovf;
        hi_val = u_sval;
        hi_ovf = u_sovf;
      end
      default: begin
        have = 1'b0;
      end
    endcase
  end

  assign kind_ovf   = do_close && have && (lo_ovf || hi_ovf);
  assign kind_range = do_close && have && !(lo_ovf || hi_ovf) && (lo_val <= hi_val);

  // next parse state and result load
  always_comb begin
    dash_cnt_nxt   = dash_cnt_r;
    phase_nxt      = phase_r;
    first_ok_nxt   = first_ok_r;
    second_ok_nxt  = second_ok_r;
    first_val_nxt  = first_val_r;
    first_ovf_nxt  = first_ovf_r;
    second_val_nxt = second_val_r;
    second_ovf_nxt = second_ovf_r;
    cur_val_nxt    = cur_val_r;
    aborted_nxt    = aborted_r;
    res_load       = 1'b0;
    ld_first       = '0;
    ld_last        = '0;
    ld_status      = ST_NO_RANGE;
    if (proc_fire) begin
      if (aborted_r) begin
        // rest of the text is discarded up to its last byte
        if (s1_eot_r) begin
          res_load    = 1'b1;
          aborted_nxt = 1'b0;
        end
      end else begin
        if (do_close) begin
          dash_cnt_nxt   = '0;
          phase_nxt      = PH_BLANK;
          first_ok_nxt   = 1'b0;
          second_ok_nxt  = 1'b0;
          first_val_nxt  = '0;
          first_ovf_nxt  = 1'b0;
          second_val_nxt = '0;
          second_ovf_nxt = 1'b0;
          cur_val_nxt    = '0;
        end else begin
          dash_cnt_nxt   = u_dash;
          phase_nxt      = u_phase;
          first_ok_nxt   = u_fok;
          second_ok_nxt  = u_sok;
          first_val_nxt  = u_fval;
          first_ovf_nxt  = u_fovf;
          second_val_nxt = u_sval;
          second_ovf_nxt = u_sovf;
          cur_val_nxt    = u_cur;
        end
        if (kind_ovf) begin
          res_load    = 1'b1;
          ld_status   = ST_OVERFLOW;
          aborted_nxt = !s1_eot_r;
        end else if (kind_range) begin
          res_load  = 1'b1;
          ld_status = ST_RANGE;
          ld_first  = lo_val;
          ld_last   = hi_val;
        end else if (s1_eot_r) begin
          res_load = 1'b1;
        end
      end
    end
  end

  // parse state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dash_cnt_r   <= '0;
      phase_r      <= PH_BLANK;
      first_ok_r   <= 1'b0;
      second_ok_r  <= 1'b0;
      first_val_r  <= '0;
      first_ovf_r  <= 1'b0;
      second_val_r <= '0;
      second_ovf_r <= 1'b0;
      cur_val_r    <= '0;
      aborted_r    <= 1'b0;
    end else begin
      dash_cnt_r   <= dash_cnt_nxt;
      phase_r      <= phase_nxt;
      first_ok_r   <= first_ok_nxt;
      second_ok_r  <= second_ok_nxt;
      first_val_r  <= first_val_nxt;
      first_ovf_r  <= first_ovf_nxt;
      second_val_r <= second_val_nxt;
      second_ovf_r <= second_ovf_nxt;
      cur_val_r    <= cur_val_nxt;
      aborted_r    <= aborted_nxt;
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_first_r  <= ld_first;
      res_last_r   <= ld_last;
      res_status_r <= ld_status;
      res_final_r  <= s1_eot_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {res_last_r, res_first_r};
  assign out_tuser  = res_status_r;
  assign out_tlast  = res_final_r;

  // checks
  `IRLP_ASSERT_NOW(a_eot_gives_result, proc_fire && s1_eot_r, res_load,
    "last byte of text produced no result")
  `IRLP_ASSERT_NOW(a_aborted_silent, proc_fire && aborted_r && !s1_eot_r, !res_load,
    "result emitted while discarding aborted text")
  `IRLP_ASSERT_NEXT(a_eot_clears, proc_fire && s1_eot_r,
    (dash_cnt_r == 2'd0) && (phase_r == PH_BLANK) && !aborted_r && (cur_val_r == '0),
    "parse state not cleared after last byte")
  `IRLP_ASSERT_NOW(a_range_order, out_valid_r && (res_status_r == ST_RANGE),
    res_first_r <= res_last_r, "range result with start above end")
  `IRLP_ASSERT_NOW(a_err_zero_ids, out_valid_r && (res_status_r != ST_RANGE),
    (res_first_r == '0) && (res_last_r == '0), "non-range result carries ids")

endmodule
